// File: hdl/brpp_pkg.sv
package brpp_pkg;

  // Pixel format codes
  localparam logic [2:0] FMT_1BPP  = 3'd0;
  localparam logic [2:0] FMT_4BPP  = 3'd1;
  localparam logic [2:0] FMT_8BPP  = 3'd2;
  localparam logic [2:0] FMT_24BPP = 3'd3;
  localparam logic [2:0] FMT_32BPP = 3'd4;
  localparam logic [2:0] FMT_MASK  = 3'd5;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_PIXEL_FORMAT       = 3'd0;
  localparam logic [2:0] REG_ROW_WIDTH          = 3'd1;
  localparam logic [2:0] REG_SOURCE_TRUECOLOR   = 3'd2;
  localparam logic [2:0] REG_TRANSPARENT_ENABLE = 3'd3;
  localparam logic [2:0] REG_TRANSPARENT_INDEX  = 3'd4;

  localparam int CFG_ADDR_W = 5;

  // Reset values
  localparam logic [2:0]  PIXEL_FORMAT_RST = FMT_8BPP;
  localparam logic [12:0] ROW_WIDTH_RST    = 13'd1;

  localparam int MAX_ROW_WIDTH_DEF = 4096;

  // Most bytes one pixel can cause: 24 bpp plus three pad bytes
  localparam int BURST_MAX = 6;

  typedef struct packed {
    logic [2:0]  pixel_format;
    logic [12:0] row_width;
    logic        source_truecolor;
    logic        transparent_enable;
    logic [7:0]  transparent_index;
    logic        clear_row;
  } cfg_t;

  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      row_end;
  } burst_t;

endpackage

// File: hdl/brpp_if.sv
interface brpp_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] palette_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [6:0] alpha;

  modport source (output valid, palette_index, red, green, blue, alpha, input ready);
  modport sink   (input valid, palette_index, red, green, blue, alpha, output ready);
endinterface

interface brpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       row_end;
  logic       last;

  modport source (output valid, data_byte, row_end, last, input ready);
  modport sink   (input valid, data_byte, row_end, last, output ready);
endinterface

// File: hdl/brpp_cfg_regs.sv
module brpp_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [brpp_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output brpp_pkg::cfg_t                     cfg
);
  import brpp_pkg::*;

  logic [2:0]  fmt_r;
  logic [12:0] width_r;
  logic        stc_r;
  logic        ten_r;
  logic [7:0]  tidx_r;
  logic        clr_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes; a format or width write restarts the row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= PIXEL_FORMAT_RST;
      width_r <= ROW_WIDTH_RST;
      stc_r   <= 1'b0;
      ten_r   <= 1'b0;
      tidx_r  <= 8'd0;
      clr_r   <= 1'b0;
    end else begin
      clr_r <= 1'b0;
      if (wr_en) begin
        case (reg_idx)
          REG_PIXEL_FORMAT: begin
            fmt_r <= pwdata[2:0];
            clr_r <= 1'b1;
          end
          REG_ROW_WIDTH: begin
            width_r <= pwdata[12:0];
            clr_r   <= 1'b1;
          end
          REG_SOURCE_TRUECOLOR:   stc_r  <= pwdata[0];
          REG_TRANSPARENT_ENABLE: ten_r  <= pwdata[0];
          REG_TRANSPARENT_INDEX:  tidx_r <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_PIXEL_FORMAT:       prdata = {29'd0, fmt_r};
      REG_ROW_WIDTH:          prdata = {19'd0, width_r};
      REG_SOURCE_TRUECOLOR:   prdata = {31'd0, stc_r};
      REG_TRANSPARENT_ENABLE: prdata = {31'd0, ten_r};
      REG_TRANSPARENT_INDEX:  prdata = {24'd0, tidx_r};
      default:                prdata = 32'd0;
    endcase
  end

  assign cfg.pixel_format       = fmt_r;
  assign cfg.row_width          = width_r;
  assign cfg.source_truecolor   = stc_r;
  assign cfg.transparent_enable = ten_r;
  assign cfg.transparent_index  = tidx_r;
  assign cfg.clear_row          = clr_r;

endmodule

// File: hdl/brpp_packer.sv
module brpp_packer #(
  parameter int MAX_ROW_WIDTH = brpp_pkg::MAX_ROW_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  brpp_pkg::cfg_t    cfg,
  brpp_pix_if.sink          in_pix,
  input  logic              burst_free,
  output logic              burst_load,
  output brpp_pkg::burst_t  burst
);
  import brpp_pkg::*;

  localparam int CW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int EW = (CW + 1 > 13) ? CW + 1 : 13;
  localparam logic [EW-1:0] MAX_W = EW'(MAX_ROW_WIDTH);

  // Input register
  logic       a_vld_r;
  logic [7:0] a_idx_r;
  logic [7:0] a_red_r;
  logic [7:0] a_grn_r;
  logic [7:0] a_blu_r;
  logic [6:0] a_alp_r;

  // Row state
  logic [CW-1:0] col_r, col_nxt;
  logic [7:0]    acc_r, acc_nxt;
  logic [2:0]    bp_r, bp_nxt;
  logic [1:0]    ph_r, ph_nxt;

  logic          a_move;
  logic [2:0]    fmt;
  logic          bitmode;
  logic          transp;
  logic [3:0]    pv;
  logic [2:0]    nb;
  logic [2:0]    shift;
  logic [7:0]    acc_pk;
  logic [7:0]    acc_a;
  logic [2:0]    bp_a;
  logic [3:0][7:0] m;
  logic [2:0]    n0;
  logic          n1;
  logic [1:0]    ph1, ph2, pad;
  logic [EW-1:0] w_eff;
  logic [EW-1:0] col_p1;
  logic          row_end;
  logic [7:0]    gray;

  assign a_move       = a_vld_r && burst_free;
  assign in_pix.ready = !a_vld_r || burst_free;
  assign burst_load   = a_move;

  // Capture the pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_pix.valid && in_pix.ready) begin
      a_vld_r <= 1'b1;
    end else if (a_move) begin
      a_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pix.valid && in_pix.ready) begin
      a_idx_r <= in_pix.palette_index;
      a_red_r <= in_pix.red;
      a_grn_r <= in_pix.green;
      a_blu_r <= in_pix.blue;
      a_alp_r <= in_pix.alpha;
    end
  end

  // Pixel mapping and byte list for the held pixel
  always_comb begin
    fmt = cfg.pixel_format;
    if (fmt > FMT_MASK) fmt = FMT_8BPP;
    bitmode = (fmt == FMT_1BPP) || (fmt == FMT_4BPP) || (fmt == FMT_MASK);

    if (cfg.source_truecolor) transp = (a_alp_r == 7'd127);
    else transp = cfg.transparent_enable && (a_idx_r == cfg.transparent_index);

    gray = 8'd255 - {a_alp_r, 1'b0} - {7'd0, a_alp_r[6]};

    if (fmt == FMT_4BPP) begin
      pv = a_idx_r[3:0];
      nb = 3'd4;
    end else if (fmt == FMT_MASK) begin
      pv = {3'd0, transp};
      nb = 3'd1;
    end else begin
      pv = {3'd0, (a_idx_r != 8'd0)};
      nb = 3'd1;
    end
    shift  = bp_r + 3'd1 - nb;
    acc_pk = acc_r | ({4'd0, pv} << shift);

    m     = '0;
    n0    = 3'd0;
    acc_a = acc_r;
    bp_a  = bp_r;
    case (fmt)
      FMT_1BPP, FMT_4BPP, FMT_MASK: begin
        if (shift == 3'd0) begin
          m[0]  = acc_pk;
          n0    = 3'd1;
          acc_a = 8'd0;
          bp_a  = 3'd7;
        end else begin
          acc_a = acc_pk;
          bp_a  = bp_r - nb;
        end
      end
      FMT_24BPP: begin
        m[0] = a_blu_r;
        m[1] = a_grn_r;
        m[2] = a_red_r;
        n0   = 3'd3;
      end
      FMT_32BPP: begin
        m[0] = a_blu_r;
        m[1] = a_grn_r;
        m[2] = a_red_r;
        m[3] = gray;
        n0   = 3'd4;
      end
      default: begin
        m[0] = a_idx_r;
        n0   = 3'd1;
      end
    endcase

    // Row end: flush partial byte, then pad to four bytes except in 32 bpp
    w_eff = EW'(cfg.row_width);
    if (w_eff == '0) w_eff = EW'(1);
    if (w_eff > MAX_W) w_eff = MAX_W;
    col_p1  = EW'(col_r) + EW'(1);
    row_end = (col_p1 >= w_eff);

    n1  = row_end && bitmode && (bp_a != 3'd7);
    ph1 = ph_r + n0[1:0];
    ph2 = ph1 + {1'b0, n1};
    pad = (row_end && (fmt != FMT_32BPP)) ? 2'(2'd0 - ph2) : 2'd0;

    burst.bytes = '0;
    burst.bytes[3:0] = m;
    if (n1) burst.bytes[0] = acc_a;
    burst.count   = n0 + {2'd0, n1} + {1'b0, pad};
    burst.row_end = row_end;

    // Next row state
    col_nxt = col_r;
    acc_nxt = acc_r;
    bp_nxt  = bp_r;
    ph_nxt  = ph_r;
    if (cfg.clear_row || (a_move && row_end)) begin
      col_nxt = '0;
      acc_nxt = 8'd0;
      bp_nxt  = 3'd7;
      ph_nxt  = 2'd0;
    end else if (a_move) begin
      col_nxt = col_r + CW'(1);
      acc_nxt = acc_a;
      bp_nxt  = bp_a;
      ph_nxt  = ph1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      acc_r <= 8'd0;
      bp_r  <= 3'd7;
      ph_r  <= 2'd0;
    end else begin
      col_r <= col_nxt;
      acc_r <= acc_nxt;
      bp_r  <= bp_nxt;
      ph_r  <= ph_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // An empty bit position means nothing is left in the accumulator
  a_acc_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (bp_r == 3'd7) |-> (acc_r == 8'd0))
    else $error("accumulator holds bits at bit position seven");

  // A finished row leaves column and phase cleared
  a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (a_move && row_end) |=> (col_r == '0) && (ph_r == 2'd0))
    else $error("row state not cleared after row end");

  // A pixel waiting on a busy serializer stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && !burst_free) |=> (a_vld_r && $stable(a_idx_r)))
    else $error("held pixel lost while serializer busy");
`endif

endmodule

// File: hdl/brpp_serializer.sv
module brpp_serializer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              burst_load,
  input  brpp_pkg::burst_t  burst,
  output logic              burst_free,
  brpp_byte_if.source       out_byte
);
  import brpp_pkg::*;

  logic                      busy_r;
  logic [BURST_MAX-1:0][7:0] bytes_r;
  logic [2:0]                cnt_r;
  logic [2:0]                ptr_r;
  logic                      rend_r;
  logic                      at_last;
  logic                      xfer;

  assign at_last    = (ptr_r == cnt_r - 3'd1);
  assign xfer       = out_byte.valid && out_byte.ready;
  assign burst_free = !busy_r || (xfer && at_last);

  assign out_byte.valid     = busy_r;
  assign out_byte.data_byte = bytes_r[ptr_r];
  assign out_byte.last      = at_last;
  assign out_byte.row_end   = at_last && rend_r;

  // Byte list held and stepped out one byte per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ptr_r  <= 3'd0;
    end else if (burst_load && (burst.count != 3'd0)) begin
      busy_r <= 1'b1;
      ptr_r  <= 3'd0;
    end else if (xfer) begin
      if (at_last) busy_r <= 1'b0;
      ptr_r <= ptr_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_load && (burst.count != 3'd0)) begin
      bytes_r <= burst.bytes;
      cnt_r   <= burst.count;
      rend_r  <= burst.row_end;
    end
  end

`ifndef NO_ASSERTIONS
  // Read pointer stays inside the held list
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (ptr_r < cnt_r))
    else $error("serializer pointer past byte count");

  // Mid-list bytes keep the serializer busy
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && !at_last) |=> busy_r)
    else $error("serializer dropped bytes of a list");
`endif

endmodule

// File: hdl/bmp_row_pixel_packer_core.sv
// BMP row pixel packer: takes one pixel per transaction and produces the bytes of
// bitmap pixel data for the selected format (1, 4 or 8 bpp palette index, 24 bpp
// B,G,R, 32 bpp B,G,R,gray, or the icon 1-bit transparency mask), packed MSB first,
// with a partial byte flushed and, except in 32 bpp, zero padding to four bytes at
// each row end. The result channel moves one byte per cycle while the receiver is
// ready. A pixel causes 0 or 1 bytes for sub-byte formats, 1 for 8 bpp, 3 for
// 24 bpp, 4 for 32 bpp, plus up to 3 pad bytes at row end (at most 6). That
// single-byte output serializer sets the sustained rate; pixels that cause no byte
// are taken every cycle while the serializer is idle. A pixel's first byte
// appears after it passes the input register into the serializer. An input
// register and the output serializer are separate stages, so a new pixel is taken
// while the previous one is still being sent. Writing pixel_format or row_width
// drops any partial row; write registers only while the block is idle.
module bmp_row_pixel_packer_core #(
  parameter int MAX_ROW_WIDTH = brpp_pkg::MAX_ROW_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  brpp_pix_if.sink                         in_pix,
  brpp_byte_if.source                      out_byte,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [brpp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import brpp_pkg::*;

  cfg_t   cfg;
  burst_t burst;
  logic   burst_load;
  logic   burst_free;

  // Configuration registers
  brpp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pixel register and byte list builder
  brpp_packer #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_pix     (in_pix),
    .burst_free (burst_free),
    .burst_load (burst_load),
    .burst      (burst)
  );

  // Output byte serializer
  brpp_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .burst_load (burst_load),
    .burst      (burst),
    .burst_free (burst_free),
    .out_byte   (out_byte)
  );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

import brpp_pkg::*;

typedef struct packed {
  logic [7:0] pal;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [6:0] alpha;
} pixel_t;

typedef struct packed {
  logic [7:0] data;
  logic       row_end;
  logic       last;
} byte_rec_t;

// Predicts the packed byte stream and checks the bytes the block sends
class row_packer_scoreboard;
  // register copies
  logic [2:0]  fmt_reg;
  logic [12:0] width_reg;
  bit          tc_src;
  bit          tr_en;
  logic [7:0]  tr_idx;

  // row packing state
  int unsigned col_idx;
  logic [7:0]  acc_bits;
  logic [2:0]  fill_pos;
  logic [1:0]  pad_phase;

  logic [7:0]  burst[$];
  byte_rec_t   expected[$];
  int          errors;
  int          seen;

  function new();
    fmt_reg   = PIXEL_FORMAT_RST;
    width_reg = ROW_WIDTH_RST;
    tc_src    = 1'b0;
    tr_en     = 1'b0;
    tr_idx    = 8'd0;
    errors    = 0;
    seen      = 0;
    clear_row();
  endfunction

  function void clear_row();
    col_idx   = 0;
    acc_bits  = 8'd0;
    fill_pos  = 3'd7;
    pad_phase = 2'd0;
  endfunction

  function int pending();
    return expected.size();
  endfunction

  function void set_reg(logic [2:0] ra, logic [31:0] v);
    case (ra)
      REG_PIXEL_FORMAT: begin
        fmt_reg = v[2:0];
        clear_row();
      end
      REG_ROW_WIDTH: begin
        width_reg = v[12:0];
        clear_row();
      end
      REG_SOURCE_TRUECOLOR:   tc_src = v[0];
      REG_TRANSPARENT_ENABLE: tr_en = v[0];
      REG_TRANSPARENT_INDEX:  tr_idx = v[7:0];
      default: ;
    endcase
  endfunction

  function void emit_byte(logic [7:0] b);
    burst.push_back(b);
    pad_phase = pad_phase + 2'd1;
  endfunction

  // MSB-first packing of 1- or 4-bit values
  function void push_bits(logic [7:0] v, logic [2:0] nb);
    logic [2:0] sh;
    sh = fill_pos + 3'd1 - nb;
    acc_bits = acc_bits | (v << sh);
    if (sh == 3'd0) begin
      emit_byte(acc_bits);
      acc_bits = 8'd0;
      fill_pos = 3'd7;
    end else begin
      fill_pos = fill_pos - nb;
    end
  endfunction

  // One accepted pixel transaction: queue the bytes it should produce
  function void take_pixel(pixel_t p);
    logic [2:0]  f;
    int unsigned w;
    int unsigned gray;
    bit          sub_byte;
    bit          hole;
    bit          row_done;
    byte_rec_t   rec;
    f = fmt_reg;
    if (f > FMT_MASK) f = FMT_8BPP;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_ROW_WIDTH_DEF) w = MAX_ROW_WIDTH_DEF;
    sub_byte = (f == FMT_1BPP) || (f == FMT_4BPP) || (f == FMT_MASK);
    burst.delete();

    case (f)
      FMT_1BPP:  push_bits((p.pal != 8'd0) ? 8'd1 : 8'd0, 3'd1);
      FMT_4BPP:  push_bits({4'd0, p.pal[3:0]}, 3'd4);
      FMT_24BPP: begin
        emit_byte(p.blue);
        emit_byte(p.green);
        emit_byte(p.red);
      end
      FMT_32BPP: begin
        // alpha 0..127 maps nearly linearly onto gray 255..0
        gray = 255 - 2 * p.alpha - (p.alpha >> 6);
        emit_byte(p.blue);
        emit_byte(p.green);
        emit_byte(p.red);
        emit_byte(gray[7:0]);
      end
      FMT_MASK: begin
        hole = tc_src ? (p.alpha == 7'd127) : (tr_en && (p.pal == tr_idx));
        push_bits(hole ? 8'd1 : 8'd0, 3'd1);
      end
      default:   emit_byte(p.pal);
    endcase

    row_done = (col_idx + 1 >= w);
    if (row_done) begin
      // flush a partial byte, then pad to 4 bytes except in 32 bpp
      if (sub_byte && fill_pos != 3'd7) emit_byte(acc_bits);
      if (f != FMT_32BPP) begin
        while (pad_phase != 2'd0) emit_byte(8'd0);
      end
      clear_row();
    end else begin
      col_idx++;
    end

    foreach (burst[k]) begin
      rec.data    = burst[k];
      rec.last    = (k == burst.size() - 1);
      rec.row_end = row_done && rec.last;
      expected.push_back(rec);
    end
  endfunction

  task report(string what);
    $display("mismatch at byte %0d: %s", seen, what);
    errors++;
  endtask

  // One accepted byte transaction
  task check_byte(byte_rec_t got);
    byte_rec_t want;
    if (expected.size() == 0) begin
      report($sformatf("byte %02h arrived with nothing expected", got.data));
      return;
    end
    want = expected.pop_front();
    if (got.data !== want.data)
      report($sformatf("data_byte got %02h want %02h", got.data, want.data));
    if (got.row_end !== want.row_end)
      report($sformatf("row_end got %0b want %0b", got.row_end, want.row_end));
    if (got.last !== want.last)
      report($sformatf("last got %0b want %0b", got.last, want.last));
    seen++;
  endtask
endclass

module testbench;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int WIDE_ITEMS    = 24;
  localparam int RANDOM_ITEMS  = 230;
  localparam int TAIL_CYCLES   = 20;
  localparam longint TIMEOUT_NS = 64'd5_000_000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  brpp_pix_if  pix_bus ();
  brpp_byte_if byte_bus ();

  row_packer_scoreboard model = new();

  bit snd_quiet = 1'b0;
  bit rcv_quiet = 1'b0;
  bit snd_rush  = 1'b0;
  bit hold_req  = 1'b0;

  bmp_row_pixel_packer_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (pix_bus),
    .out_byte (byte_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic pixel_t px(logic [7:0] pal, logic [7:0] r, logic [7:0] g,
                                logic [7:0] b, logic [6:0] a);
    pixel_t p;
    p.pal   = pal;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.alpha = a;
    return p;
  endfunction

  // Random pixel, biased toward the transparent index, zero and the alpha ends
  function automatic pixel_t rand_pixel();
    pixel_t      p;
    int unsigned pick;
    p.red   = 8'($urandom_range(0, 255));
    p.green = 8'($urandom_range(0, 255));
    p.blue  = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 7);
    p.pal = (pick < 2) ? model.tr_idx : (pick == 2) ? 8'd0 : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 7);
    p.alpha = (pick < 2) ? 7'd127 : (pick == 2) ? 7'd0 : 7'($urandom_range(0, 127));
    return p;
  endfunction

  // APB write: setup, access, then idle
  task automatic apb_write(logic [2:0] ra, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ra, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model.set_reg(ra, v);
    @(posedge clk);
  endtask

  // Drain all expected bytes, then let a zero-byte pixel finish too
  task automatic wait_idle();
    pix_bus.valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(pixel_t p);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) snd_quiet = !snd_quiet;
    gap = draw_wait(snd_quiet || snd_rush);
    if (gap > 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_bus.valid         <= 1'b1;
    pix_bus.palette_index <= p.pal;
    pix_bus.red           <= p.red;
    pix_bus.green         <= p.green;
    pix_bus.blue          <= p.blue;
    pix_bus.alpha         <= p.alpha;
    do @(posedge clk); while (!(pix_bus.valid && pix_bus.ready));
    model.take_pixel(p);
  endtask

  task automatic send_random(int n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  // Stimulus
  initial begin
    int          done_items;
    int unsigned w;
    int unsigned weff;
    int          n;
    rst_n                 <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    pix_bus.valid         <= 1'b0;
    pix_bus.palette_index <= '0;
    pix_bus.red           <= '0;
    pix_bus.green         <= '0;
    pix_bus.blue          <= '0;
    pix_bus.alpha         <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: 8 bpp, one-pixel rows
    send_pixel(px(8'h00, 8'h00, 8'h00, 8'h00, 7'd0));
    send_pixel(px(8'hff, 8'hff, 8'hff, 8'hff, 7'd127));

    // 1 bpp, partial byte flushed at row end
    wait_idle();
    apb_write(REG_PIXEL_FORMAT, FMT_1BPP);
    apb_write(REG_ROW_WIDTH, 3);
    send_pixel(px(8'h00, 8'h00, 8'h00, 8'h00, 7'd0));
    send_pixel(px(8'h01, 8'h00, 8'h00, 8'h00, 7'd0));
    send_pixel(px(8'hff, 8'h00, 8'h00, 8'h00, 7'd0));

    // 4 bpp, only the low nibble counts
    wait_idle();
    apb_write(REG_PIXEL_FORMAT, FMT_4BPP);
    send_pixel(px(8'h0f, 8'h00, 8'h00, 8'h00, 7'd0));
    send_pixel(px(8'hf0, 8'h00, 8'h00, 8'h00, 7'd0));
    send_pixel(px(8'ha5, 8'h00, 8'h00, 8'h00, 7'd0));

    // 24 bpp
    wait_idle();
    apb_write(REG_PIXEL_FORMAT, FMT_24BPP);
    apb_write(REG_ROW_WIDTH, 2);
    send_pixel(px(8'h00, 8'hff, 8'h00, 8'h80, 7'd0));
    send_pixel(px(8'hff, 8'h00, 8'hff, 8'h01, 7'd127));

    // 32 bpp, alpha extremes, no padding
    wait_idle();
    apb_write(REG_PIXEL_FORMAT, FMT_32BPP);
    send_pixel(px(8'h00, 8'h00, 8'h00, 8'h00, 7'd0));
    send_pixel(px(8'h00, 8'hff, 8'hff, 8'hff, 7'd127));

    // mask from alpha
    wait_idle();
    apb_write(REG_PIXEL_FORMAT, FMT_MASK);
    apb_write(REG_SOURCE_TRUECOLOR, 1);
    send_pixel(px(8'h00, 8'h00, 8'h00, 8'h00, 7'd127));
    send_pixel(px(8'h00, 8'h00, 8'h00, 8'h00, 7'd126));

    // mask from palette index; enable changes mid-row without clearing it
    wait_idle();
    apb_write(REG_SOURCE_TRUECOLOR, 0);
    apb_write(REG_TRANSPARENT_ENABLE, 1);
    apb_write(REG_TRANSPARENT_INDEX, 255);
    send_pixel(px(8'hff, 8'h00, 8'h00, 8'h00, 7'd127));
    wait_idle();
    apb_write(REG_TRANSPARENT_ENABLE, 0);
    send_pixel(px(8'hff, 8'h00, 8'h00, 8'h00, 7'd127));
    wait_idle();
    apb_write(REG_TRANSPARENT_ENABLE, 1);
    apb_write(REG_TRANSPARENT_INDEX, 0);
    send_pixel(px(8'h00, 8'h00, 8'h00, 8'h00, 7'd0));
    send_pixel(px(8'h00, 8'h00, 8'h00, 8'h00, 7'd0));

    // undefined format codes act as 8 bpp; width zero acts as one
    wait_idle();
    apb_write(REG_PIXEL_FORMAT, 6);
    apb_write(REG_ROW_WIDTH, 0);
    send_pixel(px(8'h5a, 8'h00, 8'h00, 8'h00, 7'd0));
    wait_idle();
    apb_write(REG_PIXEL_FORMAT, 7);
    send_pixel(px(8'ha5, 8'h00, 8'h00, 8'h00, 7'd0));

    // 1 bpp with an oversize width, back to back; the row stays open
    wait_idle();
    apb_write(REG_PIXEL_FORMAT, FMT_1BPP);
    apb_write(REG_ROW_WIDTH, 8191);
    snd_rush = 1'b1;
    send_random(WIDE_ITEMS);
    snd_rush = 1'b0;

    // maximum width, partial row dropped by the next format write
    wait_idle();
    apb_write(REG_PIXEL_FORMAT, FMT_MASK);
    apb_write(REG_ROW_WIDTH, MAX_ROW_WIDTH_DEF);
    apb_write(REG_SOURCE_TRUECOLOR, 1);
    send_random(10);

    // receiver holds off while the sender keeps going
    wait_idle();
    apb_write(REG_PIXEL_FORMAT, FMT_8BPP);
    apb_write(REG_ROW_WIDTH, 16);
    hold_req = 1'b1;
    send_random(64);

    // random phases
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      wait_idle();
      w = model.width_reg;
      if ($urandom_range(0, 3) != 0) begin
        apb_write(REG_PIXEL_FORMAT, $urandom_range(0, 7));
        case ($urandom_range(0, 9))
          0:       w = 0;
          1:       w = ($urandom_range(0, 1) == 0) ? MAX_ROW_WIDTH_DEF : 8191;
          2:       w = $urandom_range(MAX_ROW_WIDTH_DEF + 1, 8191);
          default: w = $urandom_range(1, 12);
        endcase
        apb_write(REG_ROW_WIDTH, w);
      end
      if ($urandom_range(0, 1) == 0)
        apb_write(REG_SOURCE_TRUECOLOR, $urandom_range(0, 1));
      if ($urandom_range(0, 1) == 0)
        apb_write(REG_TRANSPARENT_ENABLE, $urandom_range(0, 1));
      if ($urandom_range(0, 1) == 0)
        apb_write(REG_TRANSPARENT_INDEX,
                  ($urandom_range(0, 2) == 0) ? 0 :
                  ($urandom_range(0, 1) == 0) ? 255 : $urandom_range(0, 255));
      weff = (w == 0) ? 1 : (w > MAX_ROW_WIDTH_DEF) ? MAX_ROW_WIDTH_DEF : w;
      if (weff > 12) begin
        // huge rows: only a partial row
        n = $urandom_range(1, 8);
      end else begin
        n = weff * $urandom_range(1, 3);
        if ($urandom_range(0, 2) == 0) n += $urandom_range(0, weff - 1);
      end
      send_random(n);
      done_items += n;
    end

    // drain and finish
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (model.errors == 0 && model.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: random stalls, quiet stretches and one long hold-off
  initial begin
    int unsigned stall;
    byte_rec_t   got;
    byte_bus.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        byte_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if ($urandom_range(0, 29) == 0) rcv_quiet = !rcv_quiet;
        stall = draw_wait(rcv_quiet);
        if (stall > 0) begin
          byte_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      byte_bus.ready <= 1'b1;
      do @(posedge clk); while (!(byte_bus.valid && byte_bus.ready));
      got.data    = byte_bus.data_byte;
      got.row_end = byte_bus.row_end;
      got.last    = byte_bus.last;
      model.check_byte(got);
    end
  end

  // Run limit
  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end
endmodule

// File: files.f
hdl/brpp_pkg.sv
hdl/brpp_if.sv
hdl/brpp_cfg_regs.sv
hdl/brpp_packer.sv
hdl/brpp_serializer.sv
hdl/bmp_row_pixel_packer_core.sv
bench/testbench.sv
